// ===== hw/rtl/gpib_byte_transfer_engine_core_macros.svh =====
// assertion macros for the gpib byte transfer engine
`ifndef GPIB_BYTE_TRANSFER_ENGINE_CORE_MACROS_SVH
`define GPIB_BYTE_TRANSFER_ENGINE_CORE_MACROS_SVH

// same-cycle implication under active-low reset
`define GBTE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("gbte: same-cycle check failed");

// next-cycle implication under active-low reset
`define GBTE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("gbte: next-cycle check failed");

`endif

// ===== hw/rtl/gbte_pkg.sv =====
// types, codes and helpers shared by the gpib byte transfer engine
`default_nettype none

package gbte_pkg;

    localparam int RES_MAX   = 5;
    localparam int RES_CNT_W = 3;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_EVENT   = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_CMD   = 2'd3
    } xfer_mode_t;

    typedef enum logic [2:0] {
        ACT_MASK  = 3'd0,
        ACT_AUX   = 3'd1,
        ACT_STORE = 3'd2,
        ACT_SEND  = 3'd3,
        ACT_DONE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_ERROR    = 2'd3
    } xfer_status_t;

    typedef enum logic [0:0] {
        CFG_EOS_ENABLE = 1'b0,
        CFG_EOS_CHAR   = 1'b1
    } cfg_idx_t;

    // interrupt status bits
    localparam logic [7:0] BIT_BI  = 8'h20;
    localparam logic [7:0] BIT_BO  = 8'h10;
    localparam logic [7:0] BIT_END = 8'h08;
    localparam logic [7:0] BIT_ERR = 8'h40;

    // address status bits
    localparam logic [7:0] AS_LISTEN = 8'h04;
    localparam logic [7:0] AS_TALK   = 8'h02;
    localparam logic [7:0] AS_ATN    = 8'h20;

    // aux command codes
    localparam logic [7:0] AUX_LISTEN_OFF = 8'h09;
    localparam logic [7:0] AUX_TALK_OFF   = 8'h0A;
    localparam logic [7:0] AUX_STANDBY    = 8'h0B;
    localparam logic [7:0] AUX_FORCE_EOI  = 8'h08;
    localparam logic [7:0] AUX_NBA_FALSE  = 8'h05;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  mode;
        logic [15:0] count;
        logic        eoi_on_last;
        logic [7:0]  isr0;
        logic [7:0]  isr1;
        logic [7:0]  rx_byte;
        logic [7:0]  addr_status;
    } item_t;

    typedef struct packed {
        action_t      action;
        logic [7:0]   value;
        logic [15:0]  offset;
        xfer_status_t status;
        logic [15:0]  transferred;
        logic         last;
    } result_t;

    function automatic result_t mk_res(action_t a, logic [7:0] v, logic [15:0] o,
                                       xfer_status_t s, logic [15:0] t);
        result_t r;
        r.action      = a;
        r.value       = v;
        r.offset      = o;
        r.status      = s;
        r.transferred = t;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gbte_ifs.sv =====
// handshake channels of the gpib byte transfer engine
`default_nettype none

interface gbte_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  mode;
    logic [15:0] count;
    logic        eoi_on_last;
    logic [7:0]  isr0;
    logic [7:0]  isr1;
    logic [7:0]  rx_byte;
    logic [7:0]  addr_status;

    modport source (
        output valid, kind, mode, count, eoi_on_last, isr0, isr1, rx_byte, addr_status,
        input  ready
    );
    modport sink (
        input  valid, kind, mode, count, eoi_on_last, isr0, isr1, rx_byte, addr_status,
        output ready
    );
endinterface

interface gbte_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  value;
    logic [15:0] offset;
    logic [1:0]  status;
    logic [15:0] transferred;
    logic        last;

    modport source (
        output valid, action, value, offset, status, transferred, last,
        input  ready
    );
    modport sink (
        input  valid, action, value, offset, status, transferred, last,
        output ready
    );
endinterface

interface gbte_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/gbte_seq.sv =====
// transfer state and per-beat result list builder
`default_nettype none

module gbte_seq #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  gbte_pkg::item_t               item,
    input  logic                          eos_enable,
    input  logic [7:0]                    eos_char,
    output gbte_pkg::result_t             list [gbte_pkg::RES_MAX],
    output logic [gbte_pkg::RES_CNT_W-1:0] n
);
    import gbte_pkg::*;

    xfer_mode_t            mode_reg,   mode_next;
    logic [COUNT_BITS-1:0] left_reg,   left_next;
    logic [COUNT_BITS-1:0] offs_reg,   offs_next;
    logic [COUNT_BITS-1:0] start_reg,  start_next;
    logic                  eoi_reg,    eoi_next;
    xfer_status_t          status_reg, status_next;

    always_comb
    begin
        logic [COUNT_BITS-1:0] cnt_in;
        logic [COUNT_BITS-1:0] diff;
        logic                  complete;
        logic                  fin;
        logic                  do_done;
        logic [7:0]            fin_aux;
        logic [7:0]            fin_chk;
        logic [RES_CNT_W-1:0]  n_v;
        result_t               list_v [RES_MAX];

        mode_next   = mode_reg;
        left_next   = left_reg;
        offs_next   = offs_reg;
        start_next  = start_reg;
        eoi_next    = eoi_reg;
        status_next = status_reg;
        cnt_in      = COUNT_BITS'(item.count);
        diff        = '0;
        complete    = 1'b0;
        fin         = 1'b0;
        do_done     = 1'b0;
        fin_aux     = AUX_LISTEN_OFF;
        fin_chk     = AS_LISTEN;
        n_v         = '0;
        for (int i = 0; i < RES_MAX; i++)
        begin
            list_v[i] = '0;
        end

        case (item.kind)
            KIND_START:
            begin
                if (cnt_in == '0 || item.mode == MODE_IDLE)
                begin
                    list_v[n_v] = mk_res(ACT_DONE, 8'h00, 16'h0000, ST_ERROR, 16'h0000);
                    n_v = n_v + 3'd1;
                end
                else
                begin
                    mode_next   = xfer_mode_t'(item.mode);
                    left_next   = cnt_in;
                    start_next  = cnt_in;
                    offs_next   = '0;
                    eoi_next    = (item.mode == MODE_WRITE) && item.eoi_on_last;
                    status_next = ST_OK;
                    list_v[n_v] = mk_res(ACT_MASK,
                                         (item.mode == MODE_READ) ? BIT_BI : BIT_BO,
                                         16'h0000, ST_OK, 16'h0000);
                    n_v = n_v + 3'd1;
                end
            end
            KIND_EVENT:
            begin
                if (item.isr0 != 8'h00 || item.isr1 != 8'h00)
                begin
                    case (mode_reg)
                        MODE_IDLE:
                        begin
                            list_v[n_v] = mk_res(ACT_MASK, 8'h00, 16'h0000, ST_OK, 16'h0000);
                            n_v = n_v + 3'd1;
                        end
                        MODE_READ:
                        begin
                            if ((item.isr0 & BIT_BI) != 8'h00)
                            begin
                                list_v[n_v] = mk_res(ACT_STORE, item.rx_byte, 16'(offs_reg),
                                                     ST_OK, 16'h0000);
                                n_v = n_v + 3'd1;
                                complete  = eos_enable && (item.rx_byte == eos_char);
                                left_next = left_reg - COUNT_BITS'(1);
                                offs_next = offs_reg + COUNT_BITS'(1);
                            end
                            if ((item.isr0 & BIT_END) != 8'h00)
                            begin
                                complete = 1'b1;
                            end
                            if (!complete && left_next == '0)
                            begin
                                status_next = ST_OVERFLOW;
                                complete    = 1'b1;
                            end
                            fin     = complete;
                            fin_aux = AUX_LISTEN_OFF;
                            fin_chk = AS_LISTEN;
                        end
                        MODE_WRITE:
                        begin
                            if ((item.isr1 & BIT_ERR) != 8'h00)
                            begin
                                list_v[n_v] = mk_res(ACT_MASK, 8'h00, 16'h0000, ST_OK, 16'h0000);
                                n_v = n_v + 3'd1;
                                // give back one byte only if one went out
                                if (left_reg < start_reg)
                                begin
                                    left_next = left_reg + COUNT_BITS'(1);
                                    offs_next = offs_reg - COUNT_BITS'(1);
                                end
                                mode_next   = MODE_IDLE;
                                status_next = ST_ERROR;
                                do_done     = 1'b1;
                            end
                            else if ((item.isr0 & BIT_BO) != 8'h00)
                            begin
                                if (left_reg == '0)
                                begin
                                    fin     = 1'b1;
                                    fin_aux = AUX_TALK_OFF;
                                    fin_chk = AS_TALK;
                                end
                                else
                                begin
                                    if (left_reg == COUNT_BITS'(1) && eoi_reg)
                                    begin
                                        list_v[n_v] = mk_res(ACT_AUX, AUX_FORCE_EOI, 16'h0000,
                                                             ST_OK, 16'h0000);
                                        n_v = n_v + 3'd1;
                                    end
                                    list_v[n_v] = mk_res(ACT_SEND, 8'h00, 16'(offs_reg),
                                                         ST_OK, 16'h0000);
                                    n_v = n_v + 3'd1;
                                    left_next = left_reg - COUNT_BITS'(1);
                                    offs_next = offs_reg + COUNT_BITS'(1);
                                end
                            end
                        end
                        MODE_CMD:
                        begin
                            if ((item.isr0 & BIT_BO) != 8'h00)
                            begin
                                if (left_reg == '0)
                                begin
                                    fin     = 1'b1;
                                    fin_aux = AUX_STANDBY;
                                    fin_chk = AS_ATN;
                                end
                                else
                                begin
                                    list_v[n_v] = mk_res(ACT_SEND, 8'h00, 16'(offs_reg),
                                                         ST_OK, 16'h0000);
                                    n_v = n_v + 3'd1;
                                    left_next = left_reg - COUNT_BITS'(1);
                                    offs_next = offs_reg + COUNT_BITS'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            KIND_TIMEOUT:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    status_next = ST_TIMEOUT;
                    list_v[n_v] = mk_res(ACT_MASK, 8'h00, 16'h0000, ST_OK, 16'h0000);
                    n_v = n_v + 3'd1;
                    if (mode_reg == MODE_READ)
                    begin
                        list_v[n_v] = mk_res(ACT_AUX, AUX_LISTEN_OFF, 16'h0000, ST_OK, 16'h0000);
                        n_v = n_v + 3'd1;
                    end
                    else
                    begin
                        // write abort drops into the command cleanup
                        if (mode_reg == MODE_WRITE)
                        begin
                            list_v[n_v] = mk_res(ACT_AUX, AUX_TALK_OFF, 16'h0000,
                                                 ST_OK, 16'h0000);
                            n_v = n_v + 3'd1;
                        end
                        list_v[n_v] = mk_res(ACT_AUX, AUX_STANDBY, 16'h0000, ST_OK, 16'h0000);
                        n_v = n_v + 3'd1;
                        list_v[n_v] = mk_res(ACT_AUX, AUX_NBA_FALSE, 16'h0000, ST_OK, 16'h0000);
                        n_v = n_v + 3'd1;
                    end
                    mode_next = MODE_IDLE;
                    do_done   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // completion: mask, release command, bus check
        if (fin)
        begin
            list_v[n_v] = mk_res(ACT_MASK, 8'h00, 16'h0000, ST_OK, 16'h0000);
            n_v = n_v + 3'd1;
            list_v[n_v] = mk_res(ACT_AUX, fin_aux, 16'h0000, ST_OK, 16'h0000);
            n_v = n_v + 3'd1;
            if ((item.addr_status & fin_chk) != 8'h00)
            begin
                status_next = ST_ERROR;
            end
            mode_next = MODE_IDLE;
            do_done   = 1'b1;
        end

        if (do_done)
        begin
            diff        = start_next - left_next;
            list_v[n_v] = mk_res(ACT_DONE, 8'h00, 16'h0000, status_next, 16'(diff));
            n_v = n_v + 3'd1;
        end

        if (n_v != '0)
        begin
            list_v[n_v - 3'd1].last = 1'b1;
        end

        list = list_v;
        n    = n_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            left_reg   <= '0;
            offs_reg   <= '0;
            start_reg  <= '0;
            eoi_reg    <= 1'b0;
            status_reg <= ST_OK;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            left_reg   <= left_next;
            offs_reg   <= offs_next;
            start_reg  <= start_next;
            eoi_reg    <= eoi_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gpib_byte_transfer_engine_core.sv =====
// top level of the gpib byte transfer engine
`default_nettype none
`include "gpib_byte_transfer_engine_core_macros.svh"

// Takes one item (start, chip interrupt event or timeout) into an input register and,
// once the result queue can take it, updates the transfer state and loads every result it
// causes (none to five) into that short result queue; the queue hands out one result beat
// per cycle while the sink is ready. The input register waits until the queue is empty or
// on its last beat, and can take the next item as soon as its own item has been loaded.
// A typical byte event causes one or two results, a completing event three or four,
// and a timeout three (read), four (command write) or five (data write). Configuration
// writes are taken every cycle and should only be made while no transfer result is
// outstanding. There is no clearing pass after reset.
module gpib_byte_transfer_engine_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    gbte_cmd_if.sink    cmd,
    gbte_res_if.source  res,
    gbte_cfg_if.sink    cfg
);
    import gbte_pkg::*;

    logic                 eos_enable_reg;
    logic [7:0]           eos_char_reg;

    logic                 in_vld_reg;
    item_t                in_item_reg;
    item_t                cmd_item;

    result_t              q_reg [RES_MAX];
    logic [RES_CNT_W-1:0] q_cnt_reg;

    result_t              seq_list [RES_MAX];
    logic [RES_CNT_W-1:0] seq_n;
    logic                 load;
    logic                 take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eos_enable_reg <= 1'b0;
            eos_char_reg   <= 8'h00;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_EOS_ENABLE: eos_enable_reg <= cfg.data[0];
                CFG_EOS_CHAR:   eos_char_reg   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign cmd_item.kind        = cmd.kind;
    assign cmd_item.mode        = cmd.mode;
    assign cmd_item.count       = cmd.count;
    assign cmd_item.eoi_on_last = cmd.eoi_on_last;
    assign cmd_item.isr0        = cmd.isr0;
    assign cmd_item.isr1        = cmd.isr1;
    assign cmd_item.rx_byte     = cmd.rx_byte;
    assign cmd_item.addr_status = cmd.addr_status;

    // the queue can take a new list once it is empty or its last beat is being taken
    assign take      = (q_cnt_reg != '0) && res.ready;
    assign load      = in_vld_reg &&
                       ((q_cnt_reg == '0) || ((q_cnt_reg == RES_CNT_W'(1)) && res.ready));
    assign cmd.ready = !in_vld_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_vld_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_item_reg <= cmd_item;
        end
    end

    gbte_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (load),
        .item       (in_item_reg),
        .eos_enable (eos_enable_reg),
        .eos_char   (eos_char_reg),
        .list       (seq_list),
        .n          (seq_n)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
        end
        else if (load)
        begin
            q_cnt_reg <= seq_n;
        end
        else if (take)
        begin
            q_cnt_reg <= q_cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= seq_list;
        end
        else if (take)
        begin
            for (int i = 0; i < RES_MAX - 1; i++)
            begin
                q_reg[i] <= q_reg[i + 1];
            end
        end
    end

    assign res.valid       = (q_cnt_reg != '0);
    assign res.action      = q_reg[0].action;
    assign res.value       = q_reg[0].value;
    assign res.offset      = q_reg[0].offset;
    assign res.status      = q_reg[0].status;
    assign res.transferred = q_reg[0].transferred;
    assign res.last        = q_reg[0].last;

    `GBTE_ASSERT_IMP(a_last_on_final_beat, clk, rst_n, res.valid, res.last == (q_cnt_reg == RES_CNT_W'(1)))
    `GBTE_ASSERT_IMP(a_queue_depth, clk, rst_n, 1'b1, q_cnt_reg <= RES_CNT_W'(RES_MAX))
    `GBTE_ASSERT_NXT(a_stall_holds_queue, clk, rst_n, (q_cnt_reg != '0) && !res.ready, q_cnt_reg == $past(q_cnt_reg))
    `GBTE_ASSERT_NXT(a_accept_fills_input, clk, rst_n, cmd.valid && cmd.ready, in_vld_reg)

endmodule

`default_nettype wire
